>>> rtl/ntsp_pkg.sv
// ----------------------------------------------------------------------------
// ntsp_pkg
// Shared types and character codes for the note token stream parser.
// ----------------------------------------------------------------------------
package ntsp_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned PROD_W  = TICK_W + 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TDATA_W = 64;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_L       = 8'h4c;
  localparam logic [7:0] CH_M       = 8'h4d;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = 8'd32;

  localparam logic [1:0] PITCH_LOW  = 2'd0;
  localparam logic [1:0] PITCH_MID  = 2'd1;
  localparam logic [1:0] PITCH_HIGH = 2'd2;
  localparam logic [1:0] PITCH_TOP  = 2'd3;

  typedef enum logic [1:0] {
    KIND_NOTE    = 2'd0,
    KIND_REST    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_SLASH       = 3'd1,
    ST_BAD_TICKS      = 3'd2,
    ST_BAD_REGISTER   = 3'd3,
    ST_NO_DEGREE      = 3'd4,
    ST_DEGREE_RANGE   = 3'd5,
    ST_TOP_NOT_ONE    = 3'd6,
    ST_EXTRA_OR_EMPTY = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    LM_START   = 2'd0,
    LM_SCORE   = 2'd1,
    LM_COMMENT = 2'd2
  } line_mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         pitch_register;
    logic [2:0]         degree;
    logic               sharp;
    logic [TICK_W-1:0]  ticks;
    status_e            status;
    logic [COUNT_W-1:0] event_total;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> rtl/ntsp_core.sv
// ----------------------------------------------------------------------------
// ntsp_core
// Line and token state of the parser; turns one byte into up to two results.
// ----------------------------------------------------------------------------
module ntsp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      char_i,
  input  logic            eot_i,
  output ntsp_pkg::push_t push_o
);

  typedef struct packed {
    logic [2:0][7:0]             head;
    logic [2:0]                  head_len;
    logic                        slash;
    logic [ntsp_pkg::TICK_W-1:0] tick;
    logic                        tick_digit;
    logic                        tick_nondigit;
    logic                        tick_ovf;
  } token_t;

  typedef struct packed {
    ntsp_pkg::status_e status;
    logic [1:0]        pitch;
    logic [2:0]        deg;
    logic              sharp;
    logic              rest;
  } verdict_t;

  function automatic logic [7:0] upcase(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ntsp_pkg::CH_LOWER_A && c <= ntsp_pkg::CH_LOWER_Z) begin
      r = c - ntsp_pkg::CASE_GAP;
    end
    return r;
  endfunction

  function automatic token_t feed(token_t t, logic [7:0] c);
    token_t                      r;
    logic [ntsp_pkg::PROD_W-1:0] wide;
    logic [ntsp_pkg::PROD_W-1:0] prod;
    r    = t;
    wide = {4'b0, t.tick};
    prod = (wide << 3) + (wide << 1) + {{(ntsp_pkg::PROD_W-4){1'b0}}, c[3:0]};
    if (!t.slash) begin
      if (c == ntsp_pkg::CH_SLASH) begin
        r.slash = 1'b1;
      end else begin
        if (t.head_len < 3'd3) begin
          r.head[t.head_len[1:0]] = c;
        end
        if (t.head_len < 3'd4) begin
          r.head_len = t.head_len + 3'd1;
        end
      end
    end else if (c >= ntsp_pkg::CH_ZERO && c <= ntsp_pkg::CH_NINE) begin
      r.tick_digit = 1'b1;
      if (!t.tick_ovf) begin
        if (prod[ntsp_pkg::PROD_W-1:ntsp_pkg::TICK_W] != '0) begin
          r.tick_ovf = 1'b1;
        end else begin
          r.tick = prod[ntsp_pkg::TICK_W-1:0];
        end
      end
    end else begin
      r.tick_nondigit = 1'b1;
    end
    return r;
  endfunction

  function automatic verdict_t judge(token_t t);
    verdict_t   v;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [1:0] pitch;
    logic       pitch_ok;
    v        = '0;
    h0       = upcase(t.head[0]);
    h1       = t.head[1];
    pitch    = ntsp_pkg::PITCH_LOW;
    pitch_ok = 1'b1;
    if (h0 == ntsp_pkg::CH_L) begin
      pitch = ntsp_pkg::PITCH_LOW;
    end else if (h0 == ntsp_pkg::CH_M) begin
      pitch = ntsp_pkg::PITCH_MID;
    end else if (h0 == ntsp_pkg::CH_H) begin
      pitch = ntsp_pkg::PITCH_HIGH;
    end else if (h0 == ntsp_pkg::CH_T) begin
      pitch = ntsp_pkg::PITCH_TOP;
    end else begin
      pitch_ok = 1'b0;
    end
    priority if (!t.slash) begin
      v.status = ntsp_pkg::ST_NO_SLASH;
    end else if (!t.tick_digit || t.tick_nondigit || t.tick_ovf || t.tick == '0) begin
      v.status = ntsp_pkg::ST_BAD_TICKS;
    end else if (t.head_len == 3'd0) begin
      v.status = ntsp_pkg::ST_BAD_REGISTER;
    end else if (t.head_len == 3'd1 && h0 == ntsp_pkg::CH_R) begin
      v.rest = 1'b1;
    end else if (!pitch_ok) begin
      v.status = ntsp_pkg::ST_BAD_REGISTER;
    end else if (t.head_len < 3'd2 || h1 < ntsp_pkg::CH_ZERO || h1 > ntsp_pkg::CH_NINE) begin
      v.status = ntsp_pkg::ST_NO_DEGREE;
    end else if (h1 < ntsp_pkg::CH_ONE || h1 > ntsp_pkg::CH_SEVEN) begin
      v.status = ntsp_pkg::ST_DEGREE_RANGE;
    end else if (pitch == ntsp_pkg::PITCH_TOP && h1 != ntsp_pkg::CH_ONE) begin
      v.status = ntsp_pkg::ST_TOP_NOT_ONE;
    end else if (t.head_len > 3'd2 && (t.head[2] != ntsp_pkg::CH_HASH || t.head_len > 3'd3))
    begin
      v.status = ntsp_pkg::ST_EXTRA_OR_EMPTY;
    end else begin
      v.pitch = pitch;
      v.deg   = h1[2:0];
      v.sharp = t.head_len > 3'd2;
    end
    return v;
  endfunction

  ntsp_pkg::line_mode_e          line_mode_q, line_mode_d, mode_mid;
  token_t                        tok_q, tok_d, tok_mid;
  logic                          in_token_q, in_token_d, in_tok_mid;
  logic                          halted_q, halted_d;
  logic [ntsp_pkg::COUNT_W-1:0]  event_count_q, event_count_d, count_after;
  logic                          is_blank, is_nl, fin, ok;
  verdict_t                      verdict;
  ntsp_pkg::result_t             fin_res, sum_res;

  always_comb begin
    is_nl    = char_i == ntsp_pkg::CH_NEWLINE;
    is_blank = char_i == ntsp_pkg::CH_SPACE ||
               (char_i >= ntsp_pkg::CH_TAB && char_i <= ntsp_pkg::CH_CR);

    mode_mid   = line_mode_q;
    tok_mid    = tok_q;
    in_tok_mid = in_token_q;
    if (!halted_q && !is_blank) begin
      if (line_mode_q == ntsp_pkg::LM_START) begin
        if (char_i == ntsp_pkg::CH_HASH || char_i == ntsp_pkg::CH_SEMI) begin
          mode_mid = ntsp_pkg::LM_COMMENT;
        end else begin
          mode_mid = ntsp_pkg::LM_SCORE;
        end
      end
      if (mode_mid == ntsp_pkg::LM_SCORE) begin
        if (!in_token_q) begin
          tok_mid = '0;
        end
        in_tok_mid = 1'b1;
        tok_mid    = feed(tok_mid, char_i);
      end
    end

    fin     = !halted_q && (is_blank ? in_token_q : (eot_i && in_tok_mid));
    verdict = judge(tok_mid);
    ok      = verdict.status == ntsp_pkg::ST_OK;

    count_after = event_count_q;
    if (fin && ok && event_count_q != '1) begin
      count_after = event_count_q + 1'b1;
    end

    fin_res                = '0;
    fin_res.status         = verdict.status;
    fin_res.event_total    = count_after;
    fin_res.last_result    = !eot_i;
    if (!ok) begin
      fin_res.kind = ntsp_pkg::KIND_ERROR;
    end else if (verdict.rest) begin
      fin_res.kind  = ntsp_pkg::KIND_REST;
      fin_res.ticks = tok_mid.tick;
    end else begin
      fin_res.kind           = ntsp_pkg::KIND_NOTE;
      fin_res.pitch_register = verdict.pitch;
      fin_res.degree         = verdict.deg;
      fin_res.sharp          = verdict.sharp;
      fin_res.ticks          = tok_mid.tick;
    end

    sum_res             = '0;
    sum_res.kind        = ntsp_pkg::KIND_SUMMARY;
    sum_res.status      = (count_after == '0) ? ntsp_pkg::ST_EXTRA_OR_EMPTY : ntsp_pkg::ST_OK;
    sum_res.event_total = count_after;
    sum_res.last_result = 1'b1;

    push_o.count  = fire_i ? ({1'b0, fin} + {1'b0, eot_i}) : 2'd0;
    push_o.first  = fin ? fin_res : sum_res;
    push_o.second = sum_res;

    if (eot_i) begin
      line_mode_d   = ntsp_pkg::LM_START;
      tok_d         = '0;
      in_token_d    = 1'b0;
      halted_d      = 1'b0;
      event_count_d = '0;
    end else begin
      line_mode_d   = (!halted_q && is_nl) ? ntsp_pkg::LM_START : mode_mid;
      tok_d         = fin ? '0 : tok_mid;
      in_token_d    = fin ? 1'b0 : in_tok_mid;
      halted_d      = halted_q | (fin && !ok);
      event_count_d = count_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q   <= ntsp_pkg::LM_START;
      tok_q         <= '0;
      in_token_q    <= 1'b0;
      halted_q      <= 1'b0;
      event_count_q <= '0;
    end else if (fire_i) begin
      line_mode_q   <= line_mode_d;
      tok_q         <= tok_d;
      in_token_q    <= in_token_d;
      halted_q      <= halted_d;
      event_count_q <= event_count_d;
    end
  end

  a_halt_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !in_token_q)
    else $error("token open while halted");

  a_eot_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && eot_i) |=> (event_count_q == '0 && !halted_q && !in_token_q &&
                           line_mode_q == ntsp_pkg::LM_START))
    else $error("state not restarted after end of text");

  a_two_only_at_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (fire_i && eot_i && push_o.first.kind != ntsp_pkg::KIND_SUMMARY))
    else $error("two results without a closing token at end of text");

endmodule

>>> rtl/ntsp_out_fifo.sv
// ----------------------------------------------------------------------------
// ntsp_out_fifo
// Result queue: takes up to two results a cycle, hands out one a transfer.
// ----------------------------------------------------------------------------
module ntsp_out_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntsp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ntsp_pkg::result_t head_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  ntsp_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wp_next;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;

  always_comb begin
    valid_o = count_q != '0;
    pop     = valid_o && ready_i;
    room_o  = count_q <= CNT_W'(DEPTH - 2);
    head_o  = mem[rp_q];
    wp_next = inc(wp_q);
    count_d = count_q + CNT_W'(push_i.count) - CNT_W'(pop);
    rp_d    = pop ? inc(rp_q) : rp_q;
    unique case (push_i.count)
      2'd1:    wp_d = wp_next;
      2'd2:    wp_d = inc(wp_next);
      default: wp_d = wp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wp_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem[wp_next] <= push_i.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + (CNT_W+1)'(push_i.count) <= (CNT_W+1)'(DEPTH)))
    else $error("result queue overflow");

endmodule

>>> rtl/note_token_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// note_token_stream_parser_unit
// Score text parser: one byte in, note, rest, error and summary events out.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transfer on s_axis_tdata, s_axis_tlast set
// on the final byte of the text. Output stream: one event per transfer, kind
// on m_axis_tuser, m_axis_tlast set on the last event caused by a byte.
// A byte is taken into an input register, then handled in a step that
// updates the token state and writes zero, one or two events into a small
// result queue (FIFO_DEPTH entries). First event of a byte is presented on
// the output from the queue, after the input register and a queue write.
// Throughput: one byte per cycle while the queue has room; a byte that
// closes a token at end of text gives two events, and the queue drains
// those at one transfer per cycle while the receiver is ready.
// The input side stalls only while the queue cannot take two more events.
// Reset clears the line and token state, the event count and the queue.
// When the receiver stalls, the head event holds and the queue fills; the
// input register then holds its byte and s_axis_tready falls.
// ----------------------------------------------------------------------------
module note_token_stream_parser_unit #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] char_code
  input  logic                         s_axis_tlast,  // end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] pitch_register, [4:2] degree, [5] sharp, [37:6] ticks,
  // [40:38] status, [56:41] event_total, [63:57] zero
  output logic [ntsp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast   // last_result
);

  localparam int unsigned PAD_W = ntsp_pkg::TDATA_W - (2 + 3 + 1 + ntsp_pkg::TICK_W + 3 +
                                                       ntsp_pkg::COUNT_W);

  logic              in_vld_q;
  logic [7:0]        in_char_q;
  logic              in_eot_q;
  logic              room, fire;
  ntsp_pkg::push_t   push;
  ntsp_pkg::result_t head;

  assign fire          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  ntsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (in_char_q),
    .eot_i  (in_eot_q),
    .push_o (push)
  );

  ntsp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, head.event_total, head.status, head.ticks,
                         head.sharp, head.degree, head.pitch_register};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_result;

endmodule
